### rtl/epf_pkg.sv
// Package with the shared widths, codes and defaults of the Euler path finder.
package epf_pkg;

  localparam int VW  = 6;   // vertex number width
  localparam int NV  = 64;  // vertices reachable through a 6-bit endpoint
  localparam int KW  = 2;   // request kind width
  localparam int SW  = 3;   // status width
  localparam int CW  = 7;   // vertex_count register width
  localparam int TLW = 7;   // tour_length width

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 63;

  typedef enum logic [KW-1:0] {
    KIND_ADD     = 2'd0,
    KIND_COMPUTE = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_e;

  typedef enum logic [SW-1:0] {
    ST_TOUR     = 3'd0,
    ST_TAKEN    = 3'd1,
    ST_REJECTED = 3'd2,
    ST_ODD      = 3'd3,
    ST_DISCONN  = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_CLEARED  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEG,
    S_SCAN,
    S_DECIDE,
    S_CONN,
    S_CHECK,
    S_WSCAN,
    S_WPOP,
    S_EMRD,
    S_EMOUT,
    S_RESULT
  } state_e;

endpackage

### rtl/epf_if.sv
// Request and response channel interfaces of the Euler path finder.
interface epf_in_if;
  logic                     valid;
  logic                     ready;
  logic [epf_pkg::KW-1:0]   kind;
  logic [epf_pkg::VW-1:0]   endpoint_a;
  logic [epf_pkg::VW-1:0]   endpoint_b;
  modport source (output valid, kind, endpoint_a, endpoint_b, input ready);
  modport sink   (input valid, kind, endpoint_a, endpoint_b, output ready);
endinterface

interface epf_out_if;
  logic                     valid;
  logic                     ready;
  logic [epf_pkg::SW-1:0]   status;
  logic [epf_pkg::VW-1:0]   vertex;
  logic [epf_pkg::TLW-1:0]  tour_length;
  logic                     last;
  modport source (output valid, status, vertex, tour_length, last, input ready);
  modport sink   (input valid, status, vertex, tour_length, last, output ready);
endinterface

### rtl/euler_path_finder.sv
// Top level of the Euler path finder: edge store, checks, Hierholzer walk, tour output.
//
// Add and clear requests are handled in the idle state and answer with one response. A
// compute request on a nonzero vertex count first sweeps the edge memory once for
// degrees, scans the 64 vertex parities, then repeats connectivity sweeps over the edge
// memory until nothing changes. The walk scans the edge memory from the newest edge down
// for each step, and every tour vertex is then read from the tour memory and sent out,
// waiting while the response side stalls. Only one request is in work at a time; a new
// one is taken once the block is idle and the response register is free or being
// emptied.
module euler_path_finder #(
  parameter int MAX_VERTICES = epf_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = epf_pkg::DEF_MAX_EDGES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [epf_pkg::CW-1:0] cfg_wdata_i,
  epf_in_if.sink                 req_i,
  epf_out_if.source              rsp_o
);
  import epf_pkg::*;

  localparam int SD   = MAX_EDGES + 1;
  localparam int EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int SCW  = $clog2(MAX_EDGES + 1);
  localparam int SIW  = $clog2(SD);
  localparam int SPW  = $clog2(SD + 1);

  state_e state_q, state_d;

  logic [CW-1:0]        vc_q, vc_d;
  logic [SCW-1:0]       stored_q, stored_d;
  logic [MAX_EDGES-1:0] used_q, used_d;
  logic [NV-1:0]        parity_q, parity_d, active_q, active_d, vis_q, vis_d;
  logic [SCW-1:0]       ecnt_q, ecnt_d;
  logic                 rv_q, rv_d;
  logic [EIW-1:0]       ri_q, ri_d;
  logic                 chg_q, chg_d;
  logic [VW-1:0]        vi_q, vi_d;
  logic [1:0]           oddc_q, oddc_d;
  logic                 hodd_q, hodd_d, hact_q, hact_d;
  logic [VW-1:0]        fodd_q, fodd_d, fact_q, fact_d;
  logic [VW-1:0]        top_q, top_d;
  logic [SPW-1:0]       sp_q, sp_d, cnt_q, cnt_d, ei_q, ei_d;
  status_e              res_q, res_d;

  logic                 ov_q, ov_d;
  logic [SW-1:0]        os_q, os_d;
  logic [VW-1:0]        ovx_q, ovx_d;
  logic [TLW-1:0]       otl_q, otl_d;
  logic                 olast_q, olast_d;

  // Edge memory and the two walk memories.
  logic                 e_we;
  logic [EIW-1:0]       e_raddr;
  logic [2*VW-1:0]      e_rdata;
  logic                 s_we, t_we;
  logic [SIW-1:0]       s_waddr, s_raddr, t_raddr;
  logic [VW-1:0]        s_wdata, s_rdata, t_rdata;

  logic [VW-1:0]  ea, eb, other;
  logic           slot_free, in_acc, add_ok, issue_asc, issue_desc, hit, em_last;
  logic [SCW-1:0] ecnt_m1;
  logic [SPW-1:0] sp_m2, t_idx;
  logic [CW-1:0]  cfg_sat;

  assign ea         = e_rdata[2*VW-1:VW];
  assign eb         = e_rdata[VW-1:0];
  assign slot_free  = !ov_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && slot_free;
  assign in_acc     = req_i.valid && req_i.ready;
  assign add_ok     = ({1'b0, req_i.endpoint_a} < vc_q) && ({1'b0, req_i.endpoint_b} < vc_q)
                      && (32'(stored_q) < MAX_EDGES);
  assign issue_asc  = ecnt_q < stored_q;
  assign hit        = rv_q && !used_q[ri_q] && ((ea == top_q) || (eb == top_q));
  assign issue_desc = (ecnt_q != '0) && !hit;
  assign other      = (ea == top_q) ? eb : ea;
  assign ecnt_m1    = ecnt_q - 1'b1;
  assign sp_m2      = sp_q - SPW'(2);
  assign t_idx      = cnt_q - 1'b1 - ei_q;
  assign em_last    = (ei_q == cnt_q - 1'b1);
  assign cfg_sat    = (32'(cfg_wdata_i) > MAX_VERTICES) ? CW'(MAX_VERTICES) : cfg_wdata_i;

  assign e_we    = in_acc && (req_i.kind == KIND_ADD) && add_ok;
  assign e_raddr = (state_q == S_WSCAN) ? ecnt_m1[EIW-1:0] : ecnt_q[EIW-1:0];
  assign t_raddr = t_idx[SIW-1:0];

  epf_ram #(.W(2*VW), .D(MAX_EDGES)) u_edges (
    .clk_i, .we_i(e_we), .waddr_i(stored_q[EIW-1:0]),
    .wdata_i({req_i.endpoint_a, req_i.endpoint_b}), .raddr_i(e_raddr), .rdata_o(e_rdata)
  );
  epf_ram #(.W(VW), .D(SD)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );
  epf_ram #(.W(VW), .D(SD)) u_tour (
    .clk_i, .we_i(t_we), .waddr_i(cnt_q[SIW-1:0]), .wdata_i(top_q),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (req_i.kind == KIND_COMPUTE)) begin
          state_d = (vc_q == '0) ? S_RESULT : S_DEG;
        end
      end
      S_DEG:    if (!issue_asc && !rv_q) state_d = S_SCAN;
      S_SCAN:   if (vi_q == VW'(NV - 1)) state_d = S_DECIDE;
      S_DECIDE: state_d = (oddc_q[0] || !hact_q) ? S_RESULT : S_CONN;
      S_CONN:   if (!issue_asc && !rv_q && !chg_q) state_d = S_CHECK;
      S_CHECK:  state_d = ((active_q & ~vis_q) != '0) ? S_RESULT : S_WSCAN;
      S_WSCAN: begin
        if (!rv_q && (ecnt_q == '0)) begin
          state_d = (sp_q == SPW'(1)) ? S_EMRD : S_WPOP;
        end
      end
      S_WPOP:   state_d = S_WSCAN;
      S_EMRD:   state_d = S_EMOUT;
      S_EMOUT:  if (slot_free) state_d = em_last ? S_IDLE : S_EMRD;
      S_RESULT: if (slot_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    vc_d = vc_q;         stored_d = stored_q; used_d = used_q;
    parity_d = parity_q; active_d = active_q; vis_d = vis_q;
    ecnt_d = ecnt_q;     rv_d = 1'b0;         ri_d = ri_q;     chg_d = chg_q;
    vi_d = vi_q;         oddc_d = oddc_q;     hodd_d = hodd_q; hact_d = hact_q;
    fodd_d = fodd_q;     fact_d = fact_q;     top_d = top_q;
    sp_d = sp_q;         cnt_d = cnt_q;       ei_d = ei_q;     res_d = res_q;
    ov_d = ov_q && !rsp_o.ready;
    os_d = os_q; ovx_d = ovx_q; otl_d = otl_q; olast_d = olast_q;
    s_we = 1'b0; s_waddr = sp_q[SIW-1:0]; s_wdata = other; s_raddr = sp_m2[SIW-1:0];
    t_we = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (req_i.kind)
            KIND_ADD: begin
              ov_d = 1'b1; ovx_d = '0; otl_d = '0; olast_d = 1'b1;
              if (add_ok) begin
                os_d = ST_TAKEN;
                used_d[stored_q[EIW-1:0]] = 1'b0;
                stored_d = stored_q + 1'b1;
              end else begin
                os_d = ST_REJECTED;
              end
            end
            KIND_CLEAR: begin
              ov_d = 1'b1; os_d = ST_CLEARED; ovx_d = '0; otl_d = '0; olast_d = 1'b1;
              stored_d = '0; used_d = '0;
            end
            KIND_COMPUTE: begin
              res_d = ST_EMPTY;
              ecnt_d = '0; parity_d = '0; active_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_DEG: begin
        if (issue_asc) begin
          rv_d = 1'b1; ri_d = ecnt_q[EIW-1:0]; ecnt_d = ecnt_q + 1'b1;
        end
        if (rv_q) begin
          parity_d = parity_q ^ (NV'(1) << ea) ^ (NV'(1) << eb);
          active_d = active_q | (NV'(1) << ea) | (NV'(1) << eb);
        end
        if (!issue_asc && !rv_q) begin
          vi_d = '0; oddc_d = '0; hodd_d = 1'b0; hact_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (parity_q[vi_q]) begin
          if (oddc_q != 2'd3) oddc_d = oddc_q + 1'b1;
          if (!hodd_q) begin
            hodd_d = 1'b1; fodd_d = vi_q;
          end
        end
        if (active_q[vi_q] && !hact_q) begin
          hact_d = 1'b1; fact_d = vi_q;
        end
        vi_d = vi_q + 1'b1;
      end
      S_DECIDE: begin
        res_d = oddc_q[0] ? ST_ODD : ST_EMPTY;
        top_d = (oddc_q == 2'd2) ? fodd_q : fact_q;
        vis_d = NV'(1) << ((oddc_q == 2'd2) ? fodd_q : fact_q);
        ecnt_d = '0; chg_d = 1'b0;
      end
      S_CONN: begin
        if (issue_asc) begin
          rv_d = 1'b1; ri_d = ecnt_q[EIW-1:0]; ecnt_d = ecnt_q + 1'b1;
        end
        if (rv_q && (vis_q[ea] != vis_q[eb])) begin
          vis_d[ea] = 1'b1; vis_d[eb] = 1'b1; chg_d = 1'b1;
        end
        // Another full pass is needed whenever the last one grew the visited set.
        if (!issue_asc && !rv_q && chg_q) begin
          ecnt_d = '0; chg_d = 1'b0;
        end
      end
      S_CHECK: begin
        res_d = ST_DISCONN;
        used_d = '0; sp_d = SPW'(1); cnt_d = '0; ecnt_d = stored_q;
        s_we = 1'b1; s_waddr = '0; s_wdata = top_q;
      end
      S_WSCAN: begin
        if (issue_desc) begin
          rv_d = 1'b1; ri_d = ecnt_m1[EIW-1:0]; ecnt_d = ecnt_m1;
        end
        if (hit) begin
          // Take the edge and step along it; the scan restarts at the newest edge.
          used_d[ri_q] = 1'b1;
          s_we = 1'b1;
          sp_d = sp_q + 1'b1;
          top_d = other;
          ecnt_d = stored_q;
          rv_d = 1'b0;
        end else if (!rv_q && (ecnt_q == '0)) begin
          t_we = 1'b1;
          cnt_d = cnt_q + 1'b1;
          sp_d = sp_q - 1'b1;
          ei_d = '0;
        end
      end
      S_WPOP: begin
        top_d = s_rdata; ecnt_d = stored_q;
      end
      S_EMRD: ;
      S_EMOUT: begin
        if (slot_free) begin
          ov_d = 1'b1; os_d = ST_TOUR; ovx_d = t_rdata; otl_d = TLW'(cnt_q);
          olast_d = em_last;
          ei_d = ei_q + 1'b1;
          if (em_last) begin
            stored_d = '0; used_d = '0;
          end
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          ov_d = 1'b1; os_d = res_q; ovx_d = '0; otl_d = '0; olast_d = 1'b1;
        end
      end
      default: ;
    endcase

    if (cfg_we_i) begin
      vc_d = cfg_sat; stored_d = '0; used_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vc_q     <= '0;
      stored_q <= '0;
      used_q   <= '0;
      rv_q     <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      vc_q     <= vc_d;
      stored_q <= stored_d;
      used_q   <= used_d;
      rv_q     <= rv_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    parity_q <= parity_d; active_q <= active_d; vis_q <= vis_d;
    ecnt_q <= ecnt_d; ri_q <= ri_d; chg_q <= chg_d;
    vi_q <= vi_d; oddc_q <= oddc_d; hodd_q <= hodd_d; hact_q <= hact_d;
    fodd_q <= fodd_d; fact_q <= fact_d; top_q <= top_d;
    sp_q <= sp_d; cnt_q <= cnt_d; ei_q <= ei_d; res_q <= res_d;
    os_q <= os_d; ovx_q <= ovx_d; otl_q <= otl_d; olast_q <= olast_d;
  end

  assign rsp_o.valid       = ov_q;
  assign rsp_o.status      = os_q;
  assign rsp_o.vertex      = ovx_q;
  assign rsp_o.tour_length = otl_q;
  assign rsp_o.last        = olast_q;

`ifndef SYNTHESIS
  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(stored_q) <= MAX_EDGES)
    else $error("edge count above capacity");
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WSCAN) |-> (sp_q != '0) && (sp_q <= SPW'(stored_q) + 1'b1))
    else $error("walk stack pointer out of range");
  a_tour_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMOUT) |-> (cnt_q != '0) && (32'(cnt_q) <= SD) && (ei_q < cnt_q))
    else $error("tour index out of range");
  a_drop_after_tour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMOUT && slot_free && em_last && !cfg_we_i) |=>
      (stored_q == '0) && (used_q == '0) && (state_q == S_IDLE))
    else $error("edge store not cleared after tour");
`endif

endmodule

### rtl/epf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module epf_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
